[rtl/fmmc_pkg.sv]
`timescale 1ns / 1ps
// Package for the fuzzy min-max centroid controller.
// Holds table sizes, field widths, opcodes, table entry types and FSM states.
// No dependencies.
package fmmc_pkg;

  // Table sizes and point resolution
  localparam int INPUT_FUNCTIONS  = 5;
  localparam int OUTPUT_FUNCTIONS = 4;
  localparam int RULE_COUNT       = 16;
  localparam int POINT_BITS       = 14;

  // Fixed field widths
  localparam int OPCODE_W    = 2;
  localparam int INDEX_W     = 4;
  localparam int SLOPE_W     = 8;
  localparam int IF_MASK_W   = 5;
  localparam int THEN_MASK_W = 4;
  localparam int DEG_W       = 8;
  localparam int CRISP_W     = POINT_BITS;

  localparam logic [DEG_W-1:0] FULL_DEGREE = 8'd255;

  // Mask bits that reach a real table entry
  localparam int IN_USED  = (INPUT_FUNCTIONS < IF_MASK_W) ? INPUT_FUNCTIONS : IF_MASK_W;
  localparam int OUT_USED = (OUTPUT_FUNCTIONS < THEN_MASK_W) ? OUTPUT_FUNCTIONS : THEN_MASK_W;

  // Address widths
  localparam int IN_AW   = (INPUT_FUNCTIONS > 1) ? $clog2(INPUT_FUNCTIONS) : 1;
  localparam int OUT_AW  = (OUTPUT_FUNCTIONS > 1) ? $clog2(OUTPUT_FUNCTIONS) : 1;
  localparam int RULE_AW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;

  // Walk counter covers the deepest table
  localparam int MAX_DEPTH = (RULE_COUNT > INPUT_FUNCTIONS) ?
                             ((RULE_COUNT > OUTPUT_FUNCTIONS) ? RULE_COUNT : OUTPUT_FUNCTIONS) :
                             ((INPUT_FUNCTIONS > OUTPUT_FUNCTIONS) ? INPUT_FUNCTIONS
                                                                   : OUTPUT_FUNCTIONS);
  localparam int STEP_W = $clog2(MAX_DEPTH + 1);

  // Shift-subtract divider bit counter
  localparam int DIVK_W   = $clog2((CRISP_W > SLOPE_W) ? CRISP_W : SLOPE_W);
  localparam int SLOPE_IW = $clog2(SLOPE_W);

  // Area arithmetic widths
  localparam int AREA_W     = POINT_BITS + SLOPE_W;
  localparam int PROD_W     = AREA_W + POINT_BITS;
  localparam int SUM_GROW   = $clog2(OUTPUT_FUNCTIONS + 1);
  localparam int SUM_AREA_W = AREA_W + SUM_GROW;
  localparam int SUM_PROD_W = PROD_W + SUM_GROW;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_IN   = 2'd0,
    OP_LOAD_OUT  = 2'd1,
    OP_LOAD_RULE = 2'd2,
    OP_EVAL      = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [POINT_BITS-1:0] start_pt;
    logic [POINT_BITS-1:0] end_pt;
    logic [SLOPE_W-1:0]    rise;
    logic [SLOPE_W-1:0]    fall;
  } mship_t;

  localparam mship_t MSHIP_RESET = '{start_pt: '0, end_pt: '0,
                                     rise: SLOPE_W'(1), fall: SLOPE_W'(1)};

  typedef struct packed {
    logic [IF_MASK_W-1:0]   if_mask;
    logic [THEN_MASK_W-1:0] then_mask;
  } rule_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEG,
    ST_RULE,
    ST_OUT_RD,
    ST_OUT_DIV,
    ST_OUT_AREA,
    ST_OUT_PROD,
    ST_OUT_ACC,
    ST_QUO,
    ST_DONE
  } state_t;

endpackage

[rtl/fmmc_req_if.sv]
`timescale 1ns / 1ps
// Request channel: load and evaluate items with valid/ready handshake.
// Depends on fmmc_pkg for field widths.
interface fmmc_req_if;
  logic                                valid;
  logic                                ready;
  logic [fmmc_pkg::OPCODE_W-1:0]       opcode;
  logic [fmmc_pkg::INDEX_W-1:0]        entry_index;
  logic [fmmc_pkg::POINT_BITS-1:0]     start_point;
  logic [fmmc_pkg::POINT_BITS-1:0]     end_point;
  logic [fmmc_pkg::SLOPE_W-1:0]        rise_slope;
  logic [fmmc_pkg::SLOPE_W-1:0]        fall_slope;
  logic [fmmc_pkg::IF_MASK_W-1:0]      antecedent_mask;
  logic [fmmc_pkg::THEN_MASK_W-1:0]    consequent_mask;
  logic [fmmc_pkg::POINT_BITS-1:0]     sample;

  modport source (output valid, opcode, entry_index, start_point, end_point, rise_slope,
                  fall_slope, antecedent_mask, consequent_mask, sample, input ready);
  modport sink   (input valid, opcode, entry_index, start_point, end_point, rise_slope,
                  fall_slope, antecedent_mask, consequent_mask, sample, output ready);
endinterface

[rtl/fmmc_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel: one result per request with valid/ready handshake.
// Depends on fmmc_pkg for field widths.
interface fmmc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fmmc_pkg::CRISP_W-1:0]  crisp_output;
  logic                          no_area;
  logic                          entry_rejected;

  modport source (output valid, crisp_output, no_area, entry_rejected, input ready);
  modport sink   (input valid, crisp_output, no_area, entry_rejected, output ready);
endinterface

[rtl/fuzzy_min_max_centroid_controller_unit.sv]
`timescale 1ns / 1ps
// Load items: result registered in the cycle after the transfer.
// Evaluate items: the walk reads the three table memories (5 input and 16 rule entries,
// then each output function through the slope dividers, area, product and accumulate
// states), then the centroid divider runs. One item in flight at a time.
// Reset (synchronous, rst high) returns the FSM to idle and clears the table valid bits,
// so every table reads as its reset contents; no clearing pass is needed.
// Depends on fmmc_pkg, fmmc_req_if and fmmc_rsp_if.
module fuzzy_min_max_centroid_controller_unit (
  input logic        clk,
  input logic        rst,
  fmmc_req_if.sink   req,
  fmmc_rsp_if.source rsp
);
  import fmmc_pkg::*;

  state_t state, state_next;

  logic    accept;
  opcode_t op;
  logic    in_range;
  logic    rsp_free;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_inc;
  logic [DIVK_W-1:0] divk;

  // Read addresses from the sequencer
  logic [IN_AW-1:0]   in_raddr;
  logic [OUT_AW-1:0]  out_raddr;
  logic [RULE_AW-1:0] rule_raddr;

  // Table memories with per-entry valid bits
  mship_t in_mem   [INPUT_FUNCTIONS];
  mship_t out_mem  [OUTPUT_FUNCTIONS];
  rule_t  rule_mem [RULE_COUNT];
  logic [INPUT_FUNCTIONS-1:0]  in_vld;
  logic [OUTPUT_FUNCTIONS-1:0] out_vld;
  logic [RULE_COUNT-1:0]       rule_vld;
  mship_t in_rd, out_rd;
  rule_t  rule_rd;
  logic   in_rd_vld, out_rd_vld, rule_rd_vld;
  mship_t in_fn, out_fn;
  rule_t  rule_fn;

  logic       in_we, out_we, rule_we;
  mship_t     wr_fn;
  rule_t      wr_rule;

  // Evaluation state
  logic [POINT_BITS-1:0] x;
  logic [DEG_W-1:0]      deg      [INPUT_FUNCTIONS];
  logic [DEG_W-1:0]      strength [OUTPUT_FUNCTIONS];
  logic [DEG_W-1:0]      str_next [OUTPUT_FUNCTIONS];
  logic [DEG_W-1:0]      deg_val;
  logic [DEG_W-1:0]      rule_s;

  mship_t              cur;
  logic [DEG_W-1:0]    v;
  logic [SLOPE_W-1:0]  rem_r, rem_f, q_r, q_f;
  logic [AREA_W-1:0]   area_r;
  logic [POINT_BITS-1:0] cent_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SUM_PROD_W-1:0] sum_prod;
  logic [SUM_AREA_W-1:0] sum_area;
  logic [CRISP_W-1:0]  quo;

  logic [AREA_W-1:0]     area_val;
  logic [POINT_BITS-1:0] cent_val;

  logic                  rsp_valid;
  logic [CRISP_W-1:0]    rsp_crisp;
  logic                  rsp_none;
  logic                  rsp_rej;

  assign accept   = req.valid && req.ready;
  assign op       = opcode_t'(req.opcode);
  assign rsp_free = !rsp_valid || rsp.ready;
  assign step_inc = step + STEP_W'(1);

  // Index range check for the addressed table
  always_comb begin
    unique case (op)
      OP_LOAD_IN:   in_range = 32'(req.entry_index) < INPUT_FUNCTIONS;
      OP_LOAD_OUT:  in_range = 32'(req.entry_index) < OUTPUT_FUNCTIONS;
      OP_LOAD_RULE: in_range = 32'(req.entry_index) < RULE_COUNT;
      default:      in_range = 1'b1;
    endcase
  end

  // Write data: slopes of zero saturate to one
  always_comb begin
    wr_fn.start_pt    = req.start_point;
    wr_fn.end_pt      = req.end_point;
    wr_fn.rise        = (req.rise_slope == '0) ? SLOPE_W'(1) : req.rise_slope;
    wr_fn.fall        = (req.fall_slope == '0) ? SLOPE_W'(1) : req.fall_slope;
    wr_rule.if_mask   = req.antecedent_mask;
    wr_rule.then_mask = req.consequent_mask;
  end

  assign in_we   = accept && (op == OP_LOAD_IN)   && in_range;
  assign out_we  = accept && (op == OP_LOAD_OUT)  && in_range;
  assign rule_we = accept && (op == OP_LOAD_RULE) && in_range;

  // Valid bits: cleared by reset, set on first write
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= '0;
      out_vld  <= '0;
      rule_vld <= '0;
    end else begin
      if (in_we)   in_vld[IN_AW'(req.entry_index)]     <= 1'b1;
      if (out_we)  out_vld[OUT_AW'(req.entry_index)]   <= 1'b1;
      if (rule_we) rule_vld[RULE_AW'(req.entry_index)] <= 1'b1;
    end
  end

  // Memories: one write port, one registered read port each. Loads only land while
  // idle, so a read that the walk uses never overlaps a write to the same entry.
  always_ff @(posedge clk) begin
    if (in_we) in_mem[IN_AW'(req.entry_index)] <= wr_fn;
    in_rd     <= in_mem[in_raddr];
    in_rd_vld <= in_vld[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_we) out_mem[OUT_AW'(req.entry_index)] <= wr_fn;
    out_rd     <= out_mem[out_raddr];
    out_rd_vld <= out_vld[out_raddr];
  end

  always_ff @(posedge clk) begin
    if (rule_we) rule_mem[RULE_AW'(req.entry_index)] <= wr_rule;
    rule_rd     <= rule_mem[rule_raddr];
    rule_rd_vld <= rule_vld[rule_raddr];
  end

  assign in_fn   = in_rd_vld   ? in_rd   : MSHIP_RESET;
  assign out_fn  = out_rd_vld  ? out_rd  : MSHIP_RESET;
  assign rule_fn = rule_rd_vld ? rule_rd : '0;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept && op == OP_EVAL) state_next = ST_DEG;
      ST_DEG:      if (step == STEP_W'(INPUT_FUNCTIONS - 1)) state_next = ST_RULE;
      ST_RULE:     if (step == STEP_W'(RULE_COUNT - 1)) state_next = ST_OUT_RD;
      ST_OUT_RD:   state_next = ST_OUT_DIV;
      ST_OUT_DIV:  if (divk == '0) state_next = ST_OUT_AREA;
      ST_OUT_AREA: state_next = ST_OUT_PROD;
      ST_OUT_PROD: state_next = ST_OUT_ACC;
      ST_OUT_ACC:  state_next = (step == STEP_W'(OUTPUT_FUNCTIONS - 1)) ? ST_QUO : ST_OUT_RD;
      ST_QUO:      if (divk == '0) state_next = ST_DONE;
      ST_DONE:     if (rsp_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and read addresses, one entry ahead of use
  always_comb begin
    req.ready  = 1'b0;
    in_raddr   = '0;
    rule_raddr = '0;
    out_raddr  = '0;
    unique case (state)
      ST_IDLE:    req.ready = rsp_free;
      ST_DEG:     in_raddr = IN_AW'(step_inc);
      ST_RULE:    rule_raddr = RULE_AW'(step_inc);
      ST_OUT_ACC: out_raddr = OUT_AW'(step_inc);
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Input degree: min(rise*(x-start), fall*(end-x), full), zero outside
  always_comb begin
    logic signed [POINT_BITS:0]      d1, d2;
    logic [SLOPE_W+POINT_BITS-1:0]   m1, m2, mm;
    d1 = $signed({1'b0, x}) - $signed({1'b0, in_fn.start_pt});
    d2 = $signed({1'b0, in_fn.end_pt}) - $signed({1'b0, x});
    m1 = (SLOPE_W+POINT_BITS)'(in_fn.rise) * (SLOPE_W+POINT_BITS)'(d1[POINT_BITS-1:0]);
    m2 = (SLOPE_W+POINT_BITS)'(in_fn.fall) * (SLOPE_W+POINT_BITS)'(d2[POINT_BITS-1:0]);
    mm = (m1 < m2) ? m1 : m2;
    if (d1[POINT_BITS] || d1 == '0 || d2[POINT_BITS] || d2 == '0) begin
      deg_val = '0;
    end else if (mm > (SLOPE_W+POINT_BITS)'(FULL_DEGREE)) begin
      deg_val = FULL_DEGREE;
    end else begin
      deg_val = DEG_W'(mm);
    end
  end

  // Rule strength and max into the named output strengths
  always_comb begin
    rule_s = FULL_DEGREE;
    for (int i = 0; i < IN_USED; i++) begin
      if (rule_fn.if_mask[i] && deg[i] < rule_s) rule_s = deg[i];
    end
    for (int j = 0; j < OUTPUT_FUNCTIONS; j++) begin
      str_next[j] = strength[j];
    end
    for (int j = 0; j < OUT_USED; j++) begin
      if (rule_fn.then_mask[j] && rule_s > strength[j]) str_next[j] = rule_s;
    end
  end

  // Output area, clamped at zero, and centroid truncated toward zero
  always_comb begin
    logic signed [POINT_BITS+1:0]         base, half_sum;
    logic signed [POINT_BITS+2:0]         twice;
    logic signed [POINT_BITS+SLOPE_W+3:0] ap;
    logic signed [POINT_BITS+1:0]         cent_s;
    base  = $signed({2'b00, cur.end_pt}) - $signed({2'b00, cur.start_pt});
    twice = $signed({base, 1'b0})
          - $signed({{(POINT_BITS+3-SLOPE_W){1'b0}}, q_r})
          - $signed({{(POINT_BITS+3-SLOPE_W){1'b0}}, q_f});
    ap    = (POINT_BITS+SLOPE_W+4)'($signed({1'b0, v})) * (POINT_BITS+SLOPE_W+4)'(twice);
    area_val = ap[POINT_BITS+SLOPE_W+3] ? '0 : ap[AREA_W:1];
    half_sum = base + $signed({{(POINT_BITS+1){1'b0}}, base[POINT_BITS+1]});
    cent_s   = $signed({2'b00, cur.start_pt}) + (half_sum >>> 1);
    cent_val = cent_s[POINT_BITS-1:0];
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      divk <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (accept && op == OP_EVAL) begin
            x        <= req.sample;
            sum_prod <= '0;
            sum_area <= '0;
            quo      <= '0;
            for (int j = 0; j < OUTPUT_FUNCTIONS; j++) strength[j] <= '0;
          end
        end
        ST_DEG: begin
          deg[step[IN_AW-1:0]] <= deg_val;
          step <= (step == STEP_W'(INPUT_FUNCTIONS - 1)) ? '0 : step_inc;
        end
        ST_RULE: begin
          for (int j = 0; j < OUTPUT_FUNCTIONS; j++) strength[j] <= str_next[j];
          step <= (step == STEP_W'(RULE_COUNT - 1)) ? '0 : step_inc;
        end
        ST_OUT_RD: begin
          // Latch the function and seed both slope dividers
          cur   <= out_fn;
          v     <= strength[step[OUT_AW-1:0]];
          rem_r <= strength[step[OUT_AW-1:0]];
          rem_f <= strength[step[OUT_AW-1:0]];
          q_r   <= '0;
          q_f   <= '0;
          divk  <= DIVK_W'(SLOPE_W - 1);
        end
        ST_OUT_DIV: begin
          // One quotient bit of v/rise and v/fall per cycle
          if ({{SLOPE_W{1'b0}}, rem_r} >= ({{SLOPE_W{1'b0}}, cur.rise} << divk)) begin
            rem_r <= rem_r - SLOPE_W'(cur.rise << divk);
            q_r[divk[SLOPE_IW-1:0]] <= 1'b1;
          end
          if ({{SLOPE_W{1'b0}}, rem_f} >= ({{SLOPE_W{1'b0}}, cur.fall} << divk)) begin
            rem_f <= rem_f - SLOPE_W'(cur.fall << divk);
            q_f[divk[SLOPE_IW-1:0]] <= 1'b1;
          end
          divk <= divk - DIVK_W'(1);
        end
        ST_OUT_AREA: begin
          area_r <= area_val;
          cent_r <= cent_val;
        end
        ST_OUT_PROD: begin
          prod_r <= PROD_W'(area_r) * PROD_W'(cent_r);
        end
        ST_OUT_ACC: begin
          sum_prod <= sum_prod + SUM_PROD_W'(prod_r);
          sum_area <= sum_area + SUM_AREA_W'(area_r);
          step     <= step_inc;
          divk     <= DIVK_W'(CRISP_W - 1);
        end
        ST_QUO: begin
          // Restoring division; sum_prod holds the running remainder
          if (sum_prod >= (SUM_PROD_W'(sum_area) << divk)) begin
            sum_prod <= sum_prod - (SUM_PROD_W'(sum_area) << divk);
            quo[divk] <= 1'b1;
          end
          divk <= divk - DIVK_W'(1);
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept && op != OP_EVAL) begin
      rsp_valid <= 1'b1;
      rsp_crisp <= '0;
      rsp_none  <= 1'b0;
      rsp_rej   <= !in_range;
    end else if (state == ST_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
      rsp_crisp <= (sum_area == '0) ? '0 : quo;
      rsp_none  <= (sum_area == '0);
      rsp_rej   <= 1'b0;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.crisp_output   = rsp_crisp;
  assign rsp.no_area        = rsp_none;
  assign rsp.entry_rejected = rsp_rej;

  // An evaluate transfer blocks the request side while the walk runs
  a_eval_blocks: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.opcode == OP_EVAL |=> !req.ready)
    else $error("request taken during evaluation");

  // Zero area always comes with a zero result
  a_no_area_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.no_area |-> rsp.crisp_output == '0)
    else $error("no_area with nonzero result");

  // A result is either a load status or an evaluation, never both flags
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.no_area && rsp.entry_rejected))
    else $error("both result flags set");

  // Quotient walk starts only after the last output function is summed
  a_quo_entry: assert property (@(posedge clk) disable iff (rst)
    state == ST_QUO && $past(state) != ST_QUO |-> $past(state) == ST_OUT_ACC)
    else $error("centroid divide entered out of order");

endmodule
